// ===== rtl/slat_pkg.sv =====
`timescale 1ns / 1ps

package slat_pkg;

  // S-box word width; one parity cell per bit
  localparam int VAL_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int COUNT_W = 9;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // s_tuser codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one S-box input walking down the parity chain
  typedef struct packed {
    logic             valid;
    logic             last;   // final token of the query
    logic             cnt;    // token takes part in the count
    logic [VAL_W-1:0] x;      // S-box input i
    logic [VAL_W-1:0] y;      // S-box output S[i]
    logic             par;    // running parity of masked x and y bits
  } slat_tok_t;

endpackage

// ===== rtl/slat_cell.sv =====
`timescale 1ns / 1ps

module slat_cell
  import slat_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      mask_load,
  input  logic      mask_x_bit,
  input  logic      mask_y_bit,
  input  slat_tok_t tok_in,
  output slat_tok_t tok_out
);

  logic      mx;
  logic      my;
  slat_tok_t tok;

  always_ff @(posedge clk) begin
    if (mask_load) begin
      mx <= mask_x_bit;
      my <= mask_y_bit;
    end
  end

  // fold this cell's bit of both masked words into the parity
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
    end
    tok.last <= tok_in.last;
    tok.cnt  <= tok_in.cnt;
    tok.x    <= tok_in.x;
    tok.y    <= tok_in.y;
    tok.par  <= tok_in.par ^ (mx & tok_in.x[BIT]) ^ (my & tok_in.y[BIT]);
  end

  assign tok_out = tok;

endmodule

// ===== rtl/slat_chain.sv =====
`timescale 1ns / 1ps

module slat_chain
  import slat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             mask_load,
  input  logic [VAL_W-1:0] mask_x,
  input  logic [VAL_W-1:0] mask_y,
  input  slat_tok_t        head,
  output slat_tok_t        tail
);

  slat_tok_t link [VAL_W+1];

  assign link[0] = head;

  for (genvar k = 0; k < VAL_W; k++) begin : g_cell
    slat_cell #(
      .BIT(k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .mask_load (mask_load),
      .mask_x_bit(mask_x[k]),
      .mask_y_bit(mask_y[k]),
      .tok_in    (link[k]),
      .tok_out   (link[k+1])
    );
  end

  assign tail = link[VAL_W];

endmodule

// ===== rtl/sbox_linear_approximation_table.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: func; s_tdata: entry_index, entry_value,
//                                  mask_x, mask_y
// m        out  m_tvalid/m_tready  m_tdata: match_count
// cfg      in   cfg_we             cfg_wdata: sbox_size
//
// A load in range writes its table entry on acceptance. A query walks the first
// min(sbox_size, MAX_ENTRIES) entries one per cycle through a single-port read,
// then an 8-cell parity chain; m_tvalid rises after the last token leaves it.
// Reset clears control state and sets sbox_size to 256; table contents stay
// undefined until loaded. s_tready is low during a query and while a finished
// count waits for the output register; loads proceed while a result is held.

module sbox_linear_approximation_table
  import slat_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // entry_index, entry_value, mask_x, mask_y
  input  logic              s_tuser,   // func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // match_count, zero pad
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]  sbox_size;
  logic [VAL_W-1:0]   mem [MAX_ENTRIES];
  logic [VAL_W-1:0]   mem_q;
  logic [AW-1:0]      walk_idx;
  logic [NW-1:0]      walk_len;
  logic [NW-1:0]      count;
  logic               iss_valid;
  logic               iss_last;
  logic               iss_cnt;
  logic [VAL_W-1:0]   iss_x;
  logic [COUNT_W-1:0] match_count;
  slat_tok_t          head;
  slat_tok_t          tail;

  logic [VAL_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;
  logic [VAL_W-1:0] mask_x;
  logic [VAL_W-1:0] mask_y;
  logic             s_acc;
  logic             load_acc;
  logic             query_acc;
  logic             walk_end;
  logic             out_load;

  assign entry_index = s_tdata[7:0];
  assign entry_value = s_tdata[15:8];
  assign mask_x      = s_tdata[23:16];
  assign mask_y      = s_tdata[31:24];

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign load_acc  = s_acc && (s_tuser == FUNC_LOAD);
  assign query_acc = s_acc && (s_tuser == FUNC_QUERY);

  assign out_load  = (state == ST_FINISH) && (!m_tvalid || m_tready);

  // size above the table depth acts as the full depth
  assign walk_len = (sbox_size > SIZE_W'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(sbox_size);
  assign walk_end = (NW'(walk_idx) == walk_len - NW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sbox_size <= SIZE_RESET;
    end else if (cfg_we) begin
      sbox_size <= cfg_wdata;
    end
  end

  // drop loads beyond the table depth
  always_ff @(posedge clk) begin
    if (load_acc && ({1'b0, entry_index} < SIZE_W'(MAX_ENTRIES))) begin
      mem[entry_index[AW-1:0]] <= entry_value;
    end
    mem_q <= mem[walk_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iss_valid <= 1'b0;
      walk_idx  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          walk_idx  <= '0;
          // empty walk: one dummy token carries the zero count through
          iss_valid <= query_acc && (walk_len == '0);
          if (query_acc) begin
            if (walk_len == '0) begin
              state <= ST_DRAIN;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          iss_valid <= 1'b1;
          walk_idx  <= walk_idx + AW'(1);
          if (walk_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          iss_valid <= 1'b0;
          if (tail.valid && tail.last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          iss_valid <= 1'b0;
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          iss_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      iss_last <= 1'b1;
      iss_cnt  <= 1'b0;
      iss_x    <= '0;
    end else begin
      iss_last <= walk_end;
      iss_cnt  <= 1'b1;
      iss_x    <= VAL_W'(walk_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      count <= '0;
    end else if (tail.valid && tail.cnt && !tail.par) begin
      count <= count + NW'(1);
    end
  end

  assign match_count = COUNT_W'(count);

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(16 - COUNT_W){1'b0}}, match_count};
    end
  end

  always_comb begin
    head.valid = iss_valid;
    head.last  = iss_last;
    head.cnt   = iss_cnt;
    head.x     = iss_x;
    head.y     = mem_q;
    head.par   = 1'b0;
  end

  slat_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .mask_load(query_acc),
    .mask_x   (mask_x),
    .mask_y   (mask_y),
    .head     (head),
    .tail     (tail)
  );

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (state == ST_WALK || state == ST_DRAIN))
    else $error("query did not start a walk");

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (tail.valid && tail.last) |-> (state == ST_DRAIN))
    else $error("final token left the chain outside drain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (count <= walk_len))
    else $error("count exceeds walk length");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!tail.valid && !iss_valid))
    else $error("tokens in flight while idle");

endmodule

// ===== tb/tb_sbox_linear_approximation_table.sv =====
`timescale 1ns / 1ps

module tb_sbox_linear_approximation_table;
  import slat_pkg::*;

  localparam int TABLE_DEPTH   = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 4000;

  typedef struct packed {
    logic             func;
    logic [VAL_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
    logic [VAL_W-1:0] mask_x;
    logic [VAL_W-1:0] mask_y;
  } sbox_op_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;      // entry_index, entry_value, mask_x, mask_y
  logic              s_tuser = FUNC_LOAD; // func
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;           // match_count, zero pad
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  sbox_op_t           op_queue[$];
  logic [COUNT_W-1:0] count_queue[$];
  logic [VAL_W-1:0]   sbox_image[TABLE_DEPTH];
  logic [SIZE_W-1:0]  active_size = SIZE_RESET;
  logic [COUNT_W-1:0] expected_count;
  sbox_op_t           next_op;
  bit                 in_taken = 1'b0;
  int                 errors = 0;
  int                 n_loads = 0;
  int                 n_queries = 0;
  int                 n_counts = 0;
  int                 n_sizes = 0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 cycle_cnt = 0;
  int                 stall_mode = 0;

  sbox_linear_approximation_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count inputs below the active size whose masked input and output parities agree.
  function automatic logic [COUNT_W-1:0] lat_count(logic [VAL_W-1:0] mx,
                                                   logic [VAL_W-1:0] my);
    int                 n;
    logic [VAL_W-1:0]   x;
    logic [COUNT_W-1:0] hits;
    n = (active_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_size);
    hits = '0;
    for (int i = 0; i < n; i++) begin
      x = VAL_W'(i);
      if (^(mx & x) == ^(my & sbox_image[i])) hits++;
    end
    return hits;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (count_queue.size() == 0) begin
        $error("match_count: no transaction expected, got %0d", m_tdata[COUNT_W-1:0]);
        errors++;
      end else begin
        expected_count = count_queue.pop_front();
        n_counts++;
        if (m_tdata[COUNT_W-1:0] !== expected_count) begin
          $error("match_count: expected %0d, got %0d", expected_count,
                 m_tdata[COUNT_W-1:0]);
          errors++;
        end
      end
    end
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      if (s_tuser == FUNC_LOAD) begin
        sbox_image[s_tdata[7:0]] = s_tdata[15:8];
        n_loads++;
      end else begin
        count_queue.push_back(lat_count(s_tdata[23:16], s_tdata[31:24]));
        n_queries++;
      end
    end
  end

  // Sender: bursts of random length, random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        next_op = op_queue.pop_front();
        s_tuser <= next_op.func;
        s_tdata <= {next_op.mask_y, next_op.mask_x, next_op.entry_value,
                    next_op.entry_index};
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: periodically pick one of four stall patterns at random.
  always @(negedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ((cycle_cnt % 16) >= 12);
    endcase
  end

  task automatic push_op(logic func, int idx, int val, int mx, int my);
    sbox_op_t op;
    op.func = func;
    op.entry_index = VAL_W'(idx);
    op.entry_value = VAL_W'(val);
    op.mask_x = VAL_W'(mx);
    op.mask_y = VAL_W'(my);
    op_queue.push_back(op);
  endtask

  // Hold until every queued transaction is accepted and every count has come back.
  task automatic drain();
    int spins;
    spins = 0;
    @(posedge clk);
    while (op_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (count_queue.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    if (count_queue.size() != 0) begin
      $error("match_count: %0d expected transactions never arrived", count_queue.size());
      errors++;
      count_queue.delete();
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_size(int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= SIZE_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    active_size = SIZE_W'(value);
    n_sizes++;
  endtask

  task automatic random_phase(int n_ops);
    for (int k = 0; k < n_ops; k++) begin
      if ($urandom_range(0, 1) == 0)
        push_op(FUNC_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255));
      else
        push_op(FUNC_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int order[TABLE_DEPTH];
    int j;
    int tmp;
    int phase_size;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Entries 0..3 and 255 are loaded here; keep the size at 4 or below.
    write_size(4);
    push_op(FUNC_LOAD, 0, 8'h00, 8'hFF, 8'hFF);
    push_op(FUNC_LOAD, 1, 8'hFF, 8'h00, 8'hFF);
    push_op(FUNC_LOAD, 2, 8'h80, 8'hFF, 8'h00);
    push_op(FUNC_LOAD, 3, 8'h01, 8'h5A, 8'hA5);
    push_op(FUNC_LOAD, 255, 8'hFF, 8'hFF, 8'hFF);
    push_op(FUNC_QUERY, 8'hFF, 8'hFF, 8'h00, 8'h00);
    push_op(FUNC_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_op(FUNC_QUERY, 8'h00, 8'h00, 8'hFF, 8'h00);
    push_op(FUNC_QUERY, 8'hA5, 8'h5A, 8'h00, 8'hFF);
    push_op(FUNC_QUERY, 8'h00, 8'hFF, 8'h01, 8'h80);
    push_op(FUNC_QUERY, 8'hFF, 8'h00, 8'h80, 8'h01);
    drain();

    // Zero size: no inputs walked, count must be zero.
    write_size(0);
    push_op(FUNC_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain();

    write_size(1);
    push_op(FUNC_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    push_op(FUNC_QUERY, 8'h00, 8'h00, 8'hFF, 8'hFF);
    drain();

    // Load the whole table in shuffled order; every later query is then legal.
    write_size(TABLE_DEPTH);
    for (int i = 0; i < TABLE_DEPTH; i++) order[i] = i;
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_op(FUNC_LOAD, order[i], $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255));
    push_op(FUNC_QUERY, 0, 0, 8'h00, 8'h00);
    push_op(FUNC_QUERY, 0, 0, 8'hFF, 8'hFF);
    push_op(FUNC_QUERY, 0, 0, 8'hFF, 8'h00);
    push_op(FUNC_QUERY, 0, 0, 8'h00, 8'hFF);
    random_phase(4);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: phase_size = 511;
        1: phase_size = 2;
        2: phase_size = 255;
        3: phase_size = 0;
        default: phase_size = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 256)
                                                          : $urandom_range(2, 48);
      endcase
      write_size(phase_size);
      random_phase(24);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d loads, %0d queries and %0d counts across %0d size settings,",
             n_loads, n_queries, n_counts, n_sizes);
    $display("from an empty walk up to an oversized 511 that clamps to the full table.");
    if (errors == 0) begin
      $display("** sbox_linear_approximation_table: PASSED **");
    end else begin
      $display("** sbox_linear_approximation_table: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** sbox_linear_approximation_table: FAILED **");
    $finish;
  end

endmodule

// ===== sbox_linear_approximation_table.f =====
rtl/slat_pkg.sv
rtl/slat_cell.sv
rtl/slat_chain.sv
rtl/sbox_linear_approximation_table.sv
tb/tb_sbox_linear_approximation_table.sv
